>>> src/unbiased_dice_roll_engine_assert.svh
// ---------------------------------------------------------------------------
// unbiased_dice_roll_engine_assert.svh
// Assertion macros shared by the dice roll engine checkers.
// ---------------------------------------------------------------------------
`ifndef UNBIASED_DICE_ROLL_ENGINE_ASSERT_SVH
`define UNBIASED_DICE_ROLL_ENGINE_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define UDRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define UDRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/udre_pkg.sv
// ---------------------------------------------------------------------------
// udre_pkg
// Types and constants for the dice roll engine.
// ---------------------------------------------------------------------------
package udre_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int COUNT_W  = 8;
    localparam int SIDES_W  = 16;
    localparam int MOD_W    = 16;
    localparam int MULT_W   = 16;
    localparam int TOTAL_W  = 41;
    localparam int SEED_W   = 48;
    localparam int SUM_W    = 24;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PLAIN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TO_AVG = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPWARD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DROP   = 2'd3;

    localparam logic [COUNT_W-1:0] MAX_DICE   = 8'd255;
    localparam logic [SEED_W-1:0]  SEED_RESET = 48'd13070;

    // Generator: X' = (LCG_MUL * X + LCG_ADD) mod 2^48, multiply split in two
    localparam logic [34:0]        LCG_MUL    = 35'h5DEECE66D;
    localparam logic [17:0]        LCG_MUL_LO = LCG_MUL[17:0];
    localparam logic [16:0]        LCG_MUL_HI = LCG_MUL[34:18];
    localparam logic [SEED_W-1:0]  LCG_ADD    = 48'hB;

    // Bit-serial remainder: 33-bit dividend, one bit a step
    localparam int               DIV_W     = 33;
    localparam logic [5:0]       DIV_LAST  = 6'(DIV_W - 1);
    localparam logic [DIV_W-1:0] TWO_POW_32 = {1'b1, 32'd0};

    // Upward adjustment applies below this face value
    localparam logic [SIDES_W-1:0] UPWARD_LIMIT = 16'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXCL,
        ST_LCG_LO,
        ST_LCG_HI,
        ST_CHECK,
        ST_MOD,
        ST_ACCUM,
        ST_SCALE,
        ST_DONE
    } udre_state_t;

endpackage

>>> src/unbiased_dice_roll_engine.sv
// ---------------------------------------------------------------------------
// unbiased_dice_roll_engine
// Rejection-sampled dice roller on a 48-bit LCG, one total per request.
// ---------------------------------------------------------------------------
// One request word in, one total word out. The engine takes a request only
// while s_tready is high and then works on it alone. A request of N dice
// with at least two sides first finds 2^32 mod sides, then per die makes a
// generator draw (two multiply halves and a range check, repeated on
// rejection), reduces it in the bit-serial remainder unit and accumulates
// it. One-sided (or zero-sided) dice skip the generator, and zero dice go
// straight to the result. The remainder unit, one quotient bit a cycle,
// sets the pace. A finished total sits in the output register, so the next
// request is taken while it waits. Writing cfg_wr_data loads the generator
// state directly; write only while idle.
// ---------------------------------------------------------------------------
module unbiased_dice_roll_engine
    import udre_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    // seed_value write
    input  logic                    cfg_wr_en,
    input  logic [SEED_W-1:0]       cfg_wr_data,

    // request words
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [1:0] command, [9:2] die_count, [25:10] die_sides,
    // [41:26] roll_modifier, [57:42] roll_multiplier, [63:58] zero
    input  logic [IN_TDATA_W-1:0]   s_tdata,

    // result words
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [40:0] roll_total, [47:41] zero
    output logic [OUT_TDATA_W-1:0]  m_tdata
);

    // -------------------------------------------------------------------
    // Request fields
    // -------------------------------------------------------------------
    logic [CMD_W-1:0]   in_cmd;
    logic [COUNT_W-1:0] in_count_raw;
    logic [COUNT_W-1:0] in_count;
    logic [SIDES_W-1:0] in_sides;
    logic               in_one_sided;

    assign in_cmd       = s_tdata[1:0];
    assign in_count_raw = s_tdata[9:2];
    assign in_sides     = s_tdata[25:10];
    assign in_count     = (in_count_raw > MAX_DICE) ? MAX_DICE : in_count_raw;
    assign in_one_sided = (in_sides <= 16'd1);

    // -------------------------------------------------------------------
    // State
    // -------------------------------------------------------------------
    udre_state_t               state_reg, state_next;
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic [SIDES_W-1:0]        sides_reg, sides_next;
    logic signed [MOD_W-1:0]   mod_reg, mod_next;
    logic signed [MULT_W-1:0]  mult_reg, mult_next;
    logic [COUNT_W-1:0]        dice_left_reg, dice_left_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [SIDES_W-1:0]        lowest_reg, lowest_next;
    logic [SIDES_W-1:0]        excl_reg, excl_next;    // 2^32 mod sides
    logic [SIDES_W-1:0]        die_reg, die_next;
    logic [SEED_W-1:0]         lcg_reg, lcg_next;      // generator state
    logic [SEED_W-1:0]         lcg_part_reg, lcg_part_next;
    logic [5:0]                div_cnt_reg, div_cnt_next;
    logic [DIV_W-1:0]          div_dvd_reg, div_dvd_next;
    logic [SIDES_W-1:0]        div_rem_reg, div_rem_next;
    logic [TOTAL_W-1:0]        total_reg, total_next;
    logic [TOTAL_W-1:0]        out_data_reg, out_data_next;
    logic                      out_valid_reg, out_valid_next;

    // -------------------------------------------------------------------
    // Shared units
    // -------------------------------------------------------------------
    // generator, low half: X * mul[17:0], kept mod 2^48
    logic [SEED_W-1:0] lcg_lo_prod;
    assign lcg_lo_prod = lcg_reg * {30'd0, LCG_MUL_LO};

    // generator, high half: only X[29:0] reaches bits below 48 after << 18
    logic [29:0] lcg_hi_prod;
    logic [SEED_W-1:0] lcg_new;
    assign lcg_hi_prod = lcg_reg[29:0] * {13'd0, LCG_MUL_HI};
    assign lcg_new     = lcg_part_reg + {lcg_hi_prod, 18'd0};

    // range check: raw > 2^32-1-excl  <=>  raw + excl carries out of 32 bits
    logic [31:0] raw;
    logic [32:0] rej_sum;
    logic        reject;
    assign raw     = lcg_reg[47:16];
    assign rej_sum = {1'b0, raw} + {17'd0, excl_reg};
    assign reject  = rej_sum[32];

    // restoring remainder, one dividend bit a cycle
    logic [16:0]        div_trial;
    logic               div_ge;
    logic [SIDES_W-1:0] div_rem_step;
    logic               div_last;
    assign div_trial    = {div_rem_reg, div_dvd_reg[DIV_W-1]};
    assign div_ge       = (div_trial >= {1'b0, sides_reg});
    assign div_rem_step = div_ge ? 16'(div_trial - {1'b0, sides_reg}) : div_trial[15:0];
    assign div_last     = (div_cnt_reg == DIV_LAST);

    // die adjustment
    logic [16:0]        sides_p1;
    logic [SIDES_W-1:0] lo_avg;
    logic [SIDES_W-1:0] hi_avg;
    logic [SIDES_W-1:0] die_adj;
    logic               one_sided;
    assign sides_p1  = {1'b0, sides_reg} + 17'd1;
    assign lo_avg    = sides_p1[16:1];
    assign hi_avg    = lo_avg + {15'd0, sides_p1[0]};
    assign one_sided = (sides_reg == 16'd1);

    always_comb begin
        die_adj = die_reg;
        unique case (cmd_reg)
            CMD_TO_AVG: begin
                if (die_reg == 16'd1) begin
                    die_adj = lo_avg;
                end else if (die_reg == sides_reg) begin
                    die_adj = hi_avg;
                end
            end
            CMD_UPWARD: begin
                if (die_reg < UPWARD_LIMIT) begin
                    die_adj = die_reg + 16'd1;
                end
            end
            CMD_PLAIN, CMD_DROP: begin
                die_adj = die_reg;
            end
            default: begin
                die_adj = die_reg;
            end
        endcase
    end

    // final scaling: (sum + modifier) * multiplier
    logic signed [24:0]      mod_sum;
    logic signed [TOTAL_W-1:0] scaled;
    logic [SUM_W-1:0]        dropped;
    assign mod_sum = $signed({1'b0, sum_reg}) + $signed({{9{mod_reg[MOD_W-1]}}, mod_reg});
    assign scaled  = TOTAL_W'(mod_sum) * TOTAL_W'(mult_reg);
    assign dropped = sum_reg - {8'd0, lowest_reg};

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // -------------------------------------------------------------------
    // Sequencer: next state
    // -------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_count == '0) begin
                        state_next = ST_DONE;
                    end else if (in_one_sided) begin
                        state_next = ST_ACCUM;
                    end else begin
                        state_next = ST_EXCL;
                    end
                end
            end
            ST_EXCL: begin
                if (div_last) begin
                    state_next = ST_LCG_LO;
                end
            end
            ST_LCG_LO: state_next = ST_LCG_HI;
            ST_LCG_HI: state_next = ST_CHECK;
            ST_CHECK: begin
                state_next = reject ? ST_LCG_LO : ST_MOD;
            end
            ST_MOD: begin
                if (div_last) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                if (dice_left_reg == 8'd1) begin
                    state_next = ST_SCALE;
                end else if (one_sided) begin
                    state_next = ST_ACCUM;
                end else begin
                    state_next = ST_LCG_LO;
                end
            end
            ST_SCALE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // -------------------------------------------------------------------
    // Sequencer: datapath and outputs
    // -------------------------------------------------------------------
    always_comb begin
        cmd_next       = cmd_reg;
        sides_next     = sides_reg;
        mod_next       = mod_reg;
        mult_next      = mult_reg;
        dice_left_next = dice_left_reg;
        sum_next       = sum_reg;
        lowest_next    = lowest_reg;
        excl_next      = excl_reg;
        die_next       = die_reg;
        lcg_next       = lcg_reg;
        lcg_part_next  = lcg_part_reg;
        div_cnt_next   = div_cnt_reg;
        div_dvd_next   = div_dvd_reg;
        div_rem_next   = div_rem_reg;
        total_next     = total_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // no word taken while reset is held
                s_tready       = aresetn;
                cmd_next       = in_cmd;
                sides_next     = in_one_sided ? 16'd1 : in_sides;
                mod_next       = s_tdata[41:26];
                mult_next      = s_tdata[57:42];
                dice_left_next = in_count;
                sum_next       = '0;
                lowest_next    = '1;
                total_next     = '0;
                die_next       = 16'd1;
                div_cnt_next   = '0;
                div_dvd_next   = TWO_POW_32;
                div_rem_next   = '0;
            end
            ST_EXCL: begin
                div_cnt_next = div_cnt_reg + 6'd1;
                div_dvd_next = {div_dvd_reg[DIV_W-2:0], 1'b0};
                div_rem_next = div_rem_step;
                if (div_last) begin
                    excl_next = div_rem_step;
                end
            end
            ST_LCG_LO: begin
                lcg_part_next = lcg_lo_prod + LCG_ADD;
            end
            ST_LCG_HI: begin
                lcg_next = lcg_new;
            end
            ST_CHECK: begin
                div_cnt_next = '0;
                div_dvd_next = {1'b0, raw};
                div_rem_next = '0;
            end
            ST_MOD: begin
                div_cnt_next = div_cnt_reg + 6'd1;
                div_dvd_next = {div_dvd_reg[DIV_W-2:0], 1'b0};
                div_rem_next = div_rem_step;
                if (div_last) begin
                    die_next = div_rem_step + 16'd1;
                end
            end
            ST_ACCUM: begin
                sum_next       = sum_reg + {8'd0, die_adj};
                dice_left_next = dice_left_reg - 8'd1;
                if (die_reg < lowest_reg) begin
                    lowest_next = die_reg;
                end
            end
            ST_SCALE: begin
                unique case (cmd_reg)
                    CMD_PLAIN:              total_next = scaled;
                    CMD_DROP:               total_next = {17'd0, dropped};
                    CMD_TO_AVG, CMD_UPWARD: total_next = {17'd0, sum_reg};
                    default:                total_next = {17'd0, sum_reg};
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    out_data_next  = total_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // -------------------------------------------------------------------
    // Registers
    // -------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lcg_reg       <= SEED_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lcg_reg       <= cfg_wr_en ? cfg_wr_data : lcg_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        sides_reg     <= sides_next;
        mod_reg       <= mod_next;
        mult_reg      <= mult_next;
        dice_left_reg <= dice_left_next;
        sum_reg       <= sum_next;
        lowest_reg    <= lowest_next;
        excl_reg      <= excl_next;
        die_reg       <= die_next;
        lcg_part_reg  <= lcg_part_next;
        div_cnt_reg   <= div_cnt_next;
        div_dvd_reg   <= div_dvd_next;
        div_rem_reg   <= div_rem_next;
        total_reg     <= total_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

endmodule

>>> src/udre_checker.sv
// ---------------------------------------------------------------------------
// udre_checker
// Port-level checks for the dice roll engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "unbiased_dice_roll_engine_assert.svh"

module udre_checker
    import udre_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_wr_en,
    input logic [SEED_W-1:0]      cfg_wr_data,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic cfg_seen;
    assign cfg_seen = cfg_wr_en && (cfg_wr_data == cfg_wr_data);

    // stalled result word stays offered
    `UDRE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")

    // a request keeps the engine busy for at least the next cycle
    `UDRE_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready straight after a request word")

    // padding above the 41-bit total is zero
    `UDRE_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[47:41] == 7'd0, "nonzero padding in result word")

    // seed writes never disturb a result word in flight
    `UDRE_ASSERT_NEXT(a_cfg_quiet, cfg_seen && m_tvalid && !m_tready, $stable(m_tdata), "result word changed across seed write")

endmodule

bind unbiased_dice_roll_engine udre_checker u_udre_checker (.*);
